// File: rtl/bus_slave_memory_with_wait_states_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the bus slave memory blocks.
// ----------------------------------------------------------------------------
`ifndef BUS_SLAVE_MEMORY_WITH_WAIT_STATES_ASSERT_SVH
`define BUS_SLAVE_MEMORY_WITH_WAIT_STATES_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed in bus slave memory");

// The consequent must hold in the cycle after the antecedent.
`define BSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed in bus slave memory");

`endif

// File: rtl/bsm_pkg.sv
// ----------------------------------------------------------------------------
// bsm_pkg
// Types, widths and codes shared by the bus slave memory blocks.
// ----------------------------------------------------------------------------
package bsm_pkg;

    localparam int ADDR_W     = 32;
    localparam int DATA_W     = 32;
    localparam int WAIT_W     = 4;
    localparam int TRANS_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int MEM_DEPTH  = 4096;
    localparam int MEM_AW     = $clog2(MEM_DEPTH);

    localparam logic [ADDR_W-1:0]   MEM_LIMIT = ADDR_W'(MEM_DEPTH);
    localparam logic [MEM_AW-1:0]   MEM_LAST  = MEM_AW'(MEM_DEPTH - 1);
    localparam logic [DATA_W-1:0]   ALL_ONES  = {DATA_W{1'b1}};
    localparam logic [WAIT_W-1:0]   WAIT_RESET = WAIT_W'(1);

    localparam logic [TRANS_W-1:0] TR_IDLE   = 2'd0;
    localparam logic [TRANS_W-1:0] TR_BUSY   = 2'd1;
    localparam logic [TRANS_W-1:0] TR_NONSEQ = 2'd2;
    localparam logic [TRANS_W-1:0] TR_SEQ    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_READ_WAIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_WAIT = 2'd1;

    typedef enum logic [1:0] {
        PH_READY,
        PH_WAIT,
        PH_SERVE
    } t_phase;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_MEM,
        RD_ERR
    } t_rd_kind;

    typedef struct packed {
        logic     ready;
        logic     resp;
        t_rd_kind kind;
    } t_serve;

    typedef struct packed {
        logic              we;
        logic [MEM_AW-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [MEM_AW-1:0] raddr;
    } t_mem_req;

endpackage

// File: rtl/bsm_if.sv
// ----------------------------------------------------------------------------
// Channel interfaces
// Valid/ready channels for bus cycles, responses and register writes.
// ----------------------------------------------------------------------------
interface bsm_in_if;
    import bsm_pkg::*;
    logic               valid;
    logic               ready;
    logic [TRANS_W-1:0] trans_type;
    logic [ADDR_W-1:0]  bus_addr;
    logic               is_write;
    logic [DATA_W-1:0]  write_word;
    modport source (output valid, trans_type, bus_addr, is_write, write_word, input ready);
    modport sink   (input valid, trans_type, bus_addr, is_write, write_word, output ready);
endinterface

interface bsm_out_if;
    import bsm_pkg::*;
    logic              valid;
    logic              ready;
    logic              ready_res;
    logic              resp_error;
    logic [DATA_W-1:0] read_word;
    modport source (output valid, ready_res, resp_error, read_word, input ready);
    modport sink   (input valid, ready_res, resp_error, read_word, output ready);
endinterface

interface bsm_cfg_if;
    import bsm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/bsm_mem.sv
// ----------------------------------------------------------------------------
// bsm_mem
// Word memory with one write and one registered read port, write-first.
// ----------------------------------------------------------------------------
module bsm_mem (
    input  logic                       i_clk,
    input  bsm_pkg::t_mem_req          i_req,
    output logic [bsm_pkg::DATA_W-1:0] o_rdata
);
    import bsm_pkg::*;

    logic [DATA_W-1:0] r_mem [MEM_DEPTH];
    logic [DATA_W-1:0] r_q;
    logic [DATA_W-1:0] r_wd;
    logic              r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // A read that meets a write to the same word returns the new word.
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_q   <= r_mem[i_req.raddr];
            r_fwd <= i_req.we && (i_req.waddr == i_req.raddr);
            r_wd  <= i_req.wdata;
        end
    end

    assign o_rdata = r_fwd ? r_wd : r_q;

endmodule

// File: rtl/bsm_ctrl.sv
// ----------------------------------------------------------------------------
// bsm_ctrl
// Transfer sequencer: wait states, serving, and the write data phase.
// ----------------------------------------------------------------------------
`include "bus_slave_memory_with_wait_states_assert.svh"

module bsm_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [bsm_pkg::TRANS_W-1:0] i_trans_type,
    input  logic [bsm_pkg::ADDR_W-1:0]  i_bus_addr,
    input  logic                        i_is_write,
    input  logic [bsm_pkg::DATA_W-1:0]  i_write_word,
    input  logic [bsm_pkg::WAIT_W-1:0]  i_read_wait,
    input  logic [bsm_pkg::WAIT_W-1:0]  i_write_wait,
    output bsm_pkg::t_serve             o_serve,
    output bsm_pkg::t_mem_req           o_mem_req
);
    import bsm_pkg::*;

    t_phase            r_phase,     n_phase;
    logic [WAIT_W-1:0] r_wait_left, n_wait_left;
    logic [ADDR_W-1:0] r_held_addr, n_held_addr;
    logic              r_held_wr,   n_held_wr;
    logic              r_wr_pend,   n_wr_pend;
    logic [MEM_AW-1:0] r_pend_addr, n_pend_addr;
    logic              r_ready,     n_ready;
    logic              r_resp,      n_resp;

    logic              serve;
    logic [ADDR_W-1:0] serve_addr;
    logic              serve_wr;
    logic              in_range;
    logic [WAIT_W-1:0] cnt;
    t_rd_kind          kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_READY;
            r_wait_left <= '0;
            r_held_addr <= '0;
            r_held_wr   <= 1'b0;
            r_wr_pend   <= 1'b0;
            r_pend_addr <= '0;
            r_ready     <= 1'b1;
            r_resp      <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_wait_left <= n_wait_left;
            r_held_addr <= n_held_addr;
            r_held_wr   <= n_held_wr;
            r_wr_pend   <= n_wr_pend;
            r_pend_addr <= n_pend_addr;
            r_ready     <= n_ready;
            r_resp      <= n_resp;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_wait_left = r_wait_left;
        n_held_addr = r_held_addr;
        n_held_wr   = r_held_wr;
        n_wr_pend   = r_wr_pend;
        n_pend_addr = r_pend_addr;
        n_ready     = r_ready;
        n_resp      = r_resp;
        serve       = 1'b0;
        serve_addr  = r_held_addr;
        serve_wr    = r_held_wr;
        cnt         = '0;
        kind        = RD_NONE;
        in_range    = 1'b0;
        if (i_step) begin
            n_wr_pend = 1'b0;
            case (r_phase)
                PH_READY: begin
                    if (i_trans_type == TR_NONSEQ || i_trans_type == TR_SEQ) begin
                        n_held_addr = i_bus_addr;
                        n_held_wr   = i_is_write;
                        serve_addr  = i_bus_addr;
                        serve_wr    = i_is_write;
                        if (i_trans_type == TR_NONSEQ) begin
                            cnt = i_is_write ? i_write_wait : i_read_wait;
                        end
                        if (cnt == '0) begin
                            serve = 1'b1;
                        end else begin
                            n_wait_left = cnt - WAIT_W'(1);
                            n_phase     = (n_wait_left != '0) ? PH_WAIT : PH_SERVE;
                            n_ready     = 1'b0;
                        end
                    end
                end
                PH_WAIT: begin
                    if (r_wait_left != '0) begin
                        n_wait_left = r_wait_left - WAIT_W'(1);
                    end
                    if (n_wait_left == '0) begin
                        n_phase = PH_SERVE;
                    end
                end
                PH_SERVE: begin
                    n_ready = 1'b1;
                    serve   = 1'b1;
                    n_phase = PH_READY;
                end
                default: begin
                    n_phase = PH_READY;
                end
            endcase
            if (serve) begin
                in_range = serve_addr < MEM_LIMIT;
                n_resp   = !in_range;
                if (serve_wr) begin
                    if (in_range) begin
                        n_wr_pend   = 1'b1;
                        n_pend_addr = serve_addr[MEM_AW-1:0];
                    end
                end else begin
                    kind = in_range ? RD_MEM : RD_ERR;
                end
            end
        end
    end

    assign o_serve   = '{ready: n_ready, resp: n_resp, kind: kind};
    assign o_mem_req = '{we:    i_step && r_wr_pend,
                         waddr: r_pend_addr,
                         wdata: i_write_word,
                         re:    kind == RD_MEM,
                         raddr: serve_addr[MEM_AW-1:0]};

    `BSM_ASSERT_SAME(a_busy_not_ready, i_clk, i_rst_n, r_phase != PH_READY, !r_ready)
    `BSM_ASSERT_SAME(a_wait_count_live, i_clk, i_rst_n, r_phase == PH_WAIT, r_wait_left != '0)
    `BSM_ASSERT_NEXT(a_serve_returns, i_clk, i_rst_n, i_step && r_phase == PH_SERVE,
        r_phase == PH_READY && r_ready)

endmodule

// File: rtl/bsm_resp.sv
// ----------------------------------------------------------------------------
// bsm_resp
// Response pipeline: memory read stage and the result register.
// ----------------------------------------------------------------------------
`include "bus_slave_memory_with_wait_states_assert.svh"

module bsm_resp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  bsm_pkg::t_serve            i_serve,
    input  logic [bsm_pkg::DATA_W-1:0] i_mem_rdata,
    output logic                       o_can_take,
    bsm_out_if.source                  o_out
);
    import bsm_pkg::*;

    logic              r_mid_valid;
    t_serve            r_mid;
    logic              r_out_valid;
    logic              r_out_ready_res;
    logic              r_out_resp;
    logic [DATA_W-1:0] r_out_rdata, n_out_rdata;
    logic              mid_adv;

    assign mid_adv    = r_mid_valid && (!r_out_valid || o_out.ready);
    assign o_can_take = !r_mid_valid || mid_adv;

    always_comb begin
        case (r_mid.kind)
            RD_MEM:  n_out_rdata = i_mem_rdata;
            RD_ERR:  n_out_rdata = ALL_ONES;
            default: n_out_rdata = r_out_rdata;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_mid <= i_serve;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid     <= 1'b0;
            r_out_valid     <= 1'b0;
            r_out_ready_res <= 1'b1;
            r_out_resp      <= 1'b0;
            r_out_rdata     <= '0;
        end else begin
            if (i_step) begin
                r_mid_valid <= 1'b1;
            end else if (mid_adv) begin
                r_mid_valid <= 1'b0;
            end
            if (mid_adv) begin
                r_out_valid     <= 1'b1;
                r_out_ready_res <= r_mid.ready;
                r_out_resp      <= r_mid.resp;
                r_out_rdata     <= n_out_rdata;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.ready_res  = r_out_ready_res;
    assign o_out.resp_error = r_out_resp;
    assign o_out.read_word  = r_out_rdata;

    `BSM_ASSERT_NEXT(a_step_fills_mid, i_clk, i_rst_n, i_step, r_mid_valid)
    `BSM_ASSERT_NEXT(a_adv_fills_out, i_clk, i_rst_n, mid_adv, r_out_valid)
    `BSM_ASSERT_NEXT(a_blocked_mid_holds, i_clk, i_rst_n,
        r_mid_valid && r_out_valid && !o_out.ready, r_mid_valid)

endmodule

// File: rtl/bus_slave_memory_with_wait_states.sv
// ----------------------------------------------------------------------------
// bus_slave_memory_with_wait_states
// Word-addressed memory slave with programmable wait states on NONSEQ bus cycles.
// ----------------------------------------------------------------------------
//  Channel  Dir  Carries
//  i_in     in   trans_type, bus_addr, is_write, write_word (one bus cycle)
//  o_out    out  ready_res, resp_error, read_word (one per bus cycle)
//  i_cfg    in   index, data (0 read_wait, 1 write_wait)
//
// One bus cycle is taken per clock while no clear sweep runs and the read stage
// can take it. Its response is loaded into the memory read register when it is
// taken and then into the result register, from which it is transferred.
// After reset the memory is cleared one word a clock, all MEM_DEPTH words,
// and no bus cycle is taken until that sweep ends; register writes are taken.
// A stalled result holds the read stage, which then holds the input.
// ----------------------------------------------------------------------------
module bus_slave_memory_with_wait_states (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bsm_in_if.sink    i_in,
    bsm_out_if.source o_out,
    bsm_cfg_if.sink   i_cfg
);
    import bsm_pkg::*;

    logic [WAIT_W-1:0] r_read_wait;
    logic [WAIT_W-1:0] r_write_wait;
    logic              r_clr_busy;
    logic [MEM_AW-1:0] r_clr_addr;

    logic              step;
    logic              can_take;
    t_serve            serve;
    t_mem_req          ctrl_req;
    t_mem_req          mem_req;
    logic [DATA_W-1:0] mem_rdata;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_wait  <= WAIT_RESET;
            r_write_wait <= WAIT_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_READ_WAIT:  r_read_wait  <= i_cfg.data[WAIT_W-1:0];
                CFG_WRITE_WAIT: r_write_wait <= i_cfg.data[WAIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + MEM_AW'(1);
            if (r_clr_addr == MEM_LAST) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign i_in.ready = !r_clr_busy && can_take;
    assign step       = i_in.valid && i_in.ready;

    assign mem_req = r_clr_busy ? t_mem_req'{we: 1'b1, waddr: r_clr_addr, wdata: '0,
                                             re: 1'b0, raddr: '0}
                                : ctrl_req;

    bsm_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_trans_type (i_in.trans_type),
        .i_bus_addr   (i_in.bus_addr),
        .i_is_write   (i_in.is_write),
        .i_write_word (i_in.write_word),
        .i_read_wait  (r_read_wait),
        .i_write_wait (r_write_wait),
        .o_serve      (serve),
        .o_mem_req    (ctrl_req)
    );

    bsm_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    bsm_resp u_resp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_serve     (serve),
        .i_mem_rdata (mem_rdata),
        .o_can_take  (can_take),
        .o_out       (o_out)
    );

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the wait-state memory slave. A scoreboard class
// tracks the slave's sequencer, registers and memory, predicts the response
// of every bus cycle and compares it with each response transfer. Directed
// bus cycles come first, then random phases under several wait-state
// settings and idling patterns on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import bsm_pkg::*;

    typedef struct packed {
        logic              ready_res;
        logic              resp_error;
        logic [DATA_W-1:0] read_word;
    } t_response;

    class response_scoreboard;
        logic [WAIT_W-1:0] read_wait;
        logic [WAIT_W-1:0] write_wait;
        t_phase            phase;
        logic [WAIT_W-1:0] wait_left;
        logic [ADDR_W-1:0] held_addr;
        logic              held_is_write;
        logic              write_pending;
        logic [MEM_AW-1:0] pending_addr;
        logic              ready_q;
        logic              resp_q;
        logic [DATA_W-1:0] rdata_q;
        logic [DATA_W-1:0] mem [MEM_DEPTH];
        t_response         pending_responses[$];
        int                mismatches;

        function new();
            read_wait     = WAIT_RESET;
            write_wait    = WAIT_RESET;
            phase         = PH_READY;
            wait_left     = '0;
            held_addr     = '0;
            held_is_write = 1'b0;
            write_pending = 1'b0;
            pending_addr  = '0;
            ready_q       = 1'b1;
            resp_q        = 1'b0;
            rdata_q       = '0;
            mismatches    = 0;
            foreach (mem[i]) mem[i] = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_READ_WAIT) begin
                read_wait = value[WAIT_W-1:0];
            end else if (idx == CFG_WRITE_WAIT) begin
                write_wait = value[WAIT_W-1:0];
            end
        endfunction

        function void serve();
            logic in_range;
            in_range = held_addr < MEM_LIMIT;
            if (held_is_write) begin
                if (in_range) begin
                    pending_addr  = held_addr[MEM_AW-1:0];
                    write_pending = 1'b1;
                    resp_q        = 1'b0;
                end else begin
                    resp_q = 1'b1;
                end
            end else if (in_range) begin
                rdata_q = mem[held_addr[MEM_AW-1:0]];
                resp_q  = 1'b0;
            end else begin
                rdata_q = ALL_ONES;
                resp_q  = 1'b1;
            end
        endfunction

        // Returns 1 when the bus cycle started a transfer.
        function bit take_bus_cycle(logic [TRANS_W-1:0] tr, logic [ADDR_W-1:0] addr,
                                    logic wr, logic [DATA_W-1:0] wd);
            logic [WAIT_W-1:0] cnt;
            bit                started;
            t_response         resp;
            started = 1'b0;
            if (write_pending) begin
                mem[pending_addr] = wd;
                write_pending     = 1'b0;
            end
            case (phase)
                PH_READY: begin
                    if (tr == TR_NONSEQ || tr == TR_SEQ) begin
                        started       = 1'b1;
                        held_addr     = addr;
                        held_is_write = wr;
                        if (tr == TR_NONSEQ) begin
                            cnt = wr ? write_wait : read_wait;
                        end else begin
                            cnt = '0;
                        end
                        if (cnt == '0) begin
                            serve();
                        end else begin
                            cnt       = cnt - 1'b1;
                            wait_left = cnt;
                            phase     = (cnt >= 1) ? PH_WAIT : PH_SERVE;
                            ready_q   = 1'b0;
                        end
                    end
                end
                PH_WAIT: begin
                    if (wait_left != '0) wait_left = wait_left - 1'b1;
                    if (wait_left == '0) phase = PH_SERVE;
                end
                default: begin
                    ready_q = 1'b1;
                    serve();
                    phase = PH_READY;
                end
            endcase
            resp.ready_res  = ready_q;
            resp.resp_error = resp_q;
            resp.read_word  = rdata_q;
            pending_responses.push_back(resp);
            return started;
        endfunction

        function void check_response(logic rdy, logic err, logic [DATA_W-1:0] rd);
            t_response want;
            if (pending_responses.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected response: ready=%0b resp=%0b rdata=%08h",
                             rdy, err, rd);
                end
            end else begin
                want = pending_responses.pop_front();
                if (want.ready_res !== rdy || want.resp_error !== err ||
                    want.read_word !== rd) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected %0b/%0b/%08h, got %0b/%0b/%08h",
                                 want.ready_res, want.resp_error, want.read_word,
                                 rdy, err, rd);
                    end
                end
            end
        endfunction
    endclass

    localparam int IDLE_LIMIT = 20000;
    localparam int TRANSFERS_PER_PHASE = 175;

    logic i_clk;
    logic i_rst_n;

    bsm_in_if  bus_in ();
    bsm_out_if bus_out ();
    bsm_cfg_if cfg_bus ();

    bus_slave_memory_with_wait_states DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (bus_in),
        .o_out   (bus_out),
        .i_cfg   (cfg_bus)
    );

    response_scoreboard sb;
    int idle_mode;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic bit sender_pauses();
        case (idle_mode)
            1: return $urandom_range(99) < 60;
            3: return $urandom_range(99) < 31;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            2: return $urandom_range(99) < 60;
            3: return $urandom_range(99) < 31;
            default: return 1'b0;
        endcase
    endfunction

    initial begin
        bus_out.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            bus_out.ready <= !receiver_stalls();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && bus_out.valid && bus_out.ready) begin
            sb.check_response(bus_out.ready_res, bus_out.resp_error, bus_out.read_word);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((bus_in.valid && bus_in.ready) || (bus_out.valid && bus_out.ready) ||
                (cfg_bus.valid && cfg_bus.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[bus_slave_memory_with_wait_states] ERROR");
        $finish;
    end

    task automatic send_bus_cycle(input logic [TRANS_W-1:0] tr, input logic [ADDR_W-1:0] addr,
                                  input logic wr, input logic [DATA_W-1:0] wd,
                                  output bit started);
        @(negedge i_clk);
        while (sender_pauses()) begin
            bus_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        bus_in.valid      <= 1'b1;
        bus_in.trans_type <= tr;
        bus_in.bus_addr   <= addr;
        bus_in.is_write   <= wr;
        bus_in.write_word <= wd;
        @(posedge i_clk);
        while (!bus_in.ready) @(posedge i_clk);
        started = sb.take_bus_cycle(tr, addr, wr, wd);
    endtask

    task automatic drive(input logic [TRANS_W-1:0] tr, input logic [ADDR_W-1:0] addr,
                         input logic wr, input logic [DATA_W-1:0] wd);
        bit started;
        send_bus_cycle(tr, addr, wr, wd, started);
    endtask

    task automatic release_bus();
        @(negedge i_clk);
        bus_in.valid <= 1'b0;
    endtask

    task automatic wait_responses_done();
        release_bus();
        while (sb.pending_responses.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random_cycle(output bit started);
        logic [TRANS_W-1:0] tr;
        logic [ADDR_W-1:0]  addr;
        int                 pick;
        pick = $urandom_range(99);
        if (pick < 40) tr = TR_NONSEQ;
        else if (pick < 70) tr = TR_SEQ;
        else if (pick < 85) tr = TR_IDLE;
        else tr = TR_BUSY;
        pick = $urandom_range(99);
        if (pick < 70) addr = $urandom_range(31);
        else if (pick < 85) addr = $urandom_range(MEM_DEPTH - 1);
        else if (pick < 90) addr = MEM_LIMIT;
        else addr = $urandom;
        send_bus_cycle(tr, addr, 1'($urandom_range(1)), $urandom, started);
    endtask

    // Brings the sequencer back to its ready phase and drains all responses.
    task automatic settle_block();
        while (sb.phase != PH_READY || sb.write_pending) begin
            drive(TR_IDLE, $urandom, 1'($urandom_range(1)), $urandom);
        end
        wait_responses_done();
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WAIT_W-1:0] value);
        logic [CFG_DATA_W-1:0] data;
        data = $urandom;
        data[WAIT_W-1:0] = value;
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        sb.set_reg(idx, data);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    initial begin
        logic [WAIT_W-1:0] read_set  [6];
        logic [WAIT_W-1:0] write_set [6];
        bit                started;
        int                transfers;
        bit                paused_once;

        sb                = new();
        idle_mode         = 0;
        paused_once       = 1'b0;
        i_rst_n           = 1'b0;
        bus_in.valid      = 1'b0;
        bus_in.trans_type = TR_IDLE;
        bus_in.bus_addr   = '0;
        bus_in.is_write   = 1'b0;
        bus_in.write_word = '0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.index     = CFG_READ_WAIT;
        cfg_bus.data      = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset wait states: one for each direction.
        drive(TR_IDLE,   32'hFFFF_FFFF, 1'b1, 32'h0000_0000);
        drive(TR_BUSY,   32'h0000_0005, 1'b0, 32'hFFFF_FFFF);
        drive(TR_NONSEQ, 32'h0000_0005, 1'b1, 32'h1234_5678);
        drive(TR_SEQ,    32'h0000_0006, 1'b1, 32'h0000_0000);
        drive(TR_IDLE,   32'h0000_0000, 1'b0, 32'hFFFF_FFFF);
        drive(TR_NONSEQ, 32'h0000_0005, 1'b0, 32'h0000_0000);
        drive(TR_BUSY,   32'h0000_0000, 1'b0, 32'h0000_0000);
        drive(TR_IDLE,   32'h0000_0000, 1'b0, 32'h0000_0000);
        drive(TR_SEQ,    MEM_LIMIT - 1, 1'b1, 32'h0000_0000);
        drive(TR_SEQ,    MEM_LIMIT - 1, 1'b0, 32'hA5A5_5A5A);
        drive(TR_NONSEQ, MEM_LIMIT,     1'b0, 32'h0000_0000);
        drive(TR_IDLE,   32'h0000_0000, 1'b0, 32'h0000_0000);
        drive(TR_SEQ,    32'hFFFF_FFFF, 1'b1, 32'hDEAD_BEEF);
        drive(TR_SEQ,    32'h0000_0000, 1'b0, 32'h0000_0000);
        drive(TR_SEQ,    32'h8000_0000, 1'b0, 32'h0000_0000);
        drive(TR_NONSEQ, MEM_LIMIT,     1'b1, 32'hFFFF_FFFF);
        drive(TR_IDLE,   32'h0000_0000, 1'b0, 32'h0000_0000);
        drive(TR_SEQ,    MEM_LIMIT - 1, 1'b0, 32'h0000_0000);
        drive(TR_SEQ,    32'h0000_0005, 1'b0, 32'h0000_0000);
        drive(TR_IDLE,   32'h5555_5555, 1'b1, 32'h0000_0000);
        settle_block();

        read_set  = '{4'd0, 4'd15, 4'd0,  4'd15, 4'd1, 4'd0};
        write_set = '{4'd0, 4'd15, 4'd15, 4'd0,  4'd0, 4'd1};
        read_set[4]  = WAIT_W'($urandom_range(15));
        write_set[4] = WAIT_W'($urandom_range(15));

        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_READ_WAIT, read_set[p]);
            write_reg(CFG_WRITE_WAIT, write_set[p]);
            idle_mode = p % 4;
            transfers = 0;
            while (transfers < TRANSFERS_PER_PHASE) begin
                send_random_cycle(started);
                transfers++;
                if (!paused_once && p == 1 && started &&
                    transfers >= TRANSFERS_PER_PHASE / 2) begin
                    paused_once = 1'b1;
                    wait_responses_done();
                end
            end
            settle_block();
        end

        idle_mode = 0;
        wait_responses_done();
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_responses.size() == 0) begin
            $display("[bus_slave_memory_with_wait_states] OK");
        end else begin
            $display("[bus_slave_memory_with_wait_states] ERROR");
        end
        $finish;
    end
endmodule
